// ===== rtl/core/kfli_pkg.sv =====
package kfli_pkg;

    localparam int MAX_KEYS_DEF       = 16;
    localparam int MAX_COMPONENTS_DEF = 4;
    localparam int QUEUE_DEPTH        = 2;

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_EVAL   = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]         kind;
        logic [31:0]        time_point;
        logic [2:0]         component_count;
        logic signed [31:0] in_value0;
        logic signed [31:0] in_value1;
        logic signed [31:0] in_value2;
        logic signed [31:0] in_value3;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [2:0]         result_count;
        logic signed [31:0] out_value0;
        logic signed [31:0] out_value1;
        logic signed [31:0] out_value2;
        logic signed [31:0] out_value3;
    } t_out_item;

    // Classified item passed from front to back
    typedef struct packed {
        t_kind       kind;
        logic [31:0] time_point;
        logic [2:0]  component_count;
        logic [3:0][31:0] values;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_FIRST,
        S_CHK_FIRST,
        S_RD_LAST,
        S_CHK_LAST,
        S_SRCH_RD,
        S_SRCH_WAIT,
        S_SRCH_CHK,
        S_PAIR_RD,
        S_PAIR_WAIT,
        S_PAIR_SET,
        S_COMP_RD,
        S_DIV,
        S_COMP_WR,
        S_OUT
    } t_state;

endpackage

// ===== rtl/core/keyframe_linear_interpolator.sv =====
// Keyframe linear interpolator. Items clear the key table, append a keyframe
// (time plus up to four Q16.16 components) or evaluate at a query time; each
// item gives exactly one result. An evaluation runs a binary search over the
// stored keys, then per component reads the values of the two bracketing keys
// and divides in a restoring divider; a query outside the keys copies the
// nearest key's values. The back end takes one item at a time; a two-entry queue
// lets new items arrive while the back end works.
module keyframe_linear_interpolator #(
    parameter int MAX_KEYS       = kfli_pkg::MAX_KEYS_DEF,
    parameter int MAX_COMPONENTS = kfli_pkg::MAX_COMPONENTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  kfli_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output kfli_pkg::t_out_item o_item
);
    import kfli_pkg::*;

    logic w_cmd_valid, w_cmd_ready;
    t_cmd w_cmd;

    kfli_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_item     (i_item),
        .o_cmd_valid(w_cmd_valid),
        .i_cmd_ready(w_cmd_ready),
        .o_cmd      (w_cmd)
    );

    kfli_back #(
        .MAX_KEYS      (MAX_KEYS),
        .MAX_COMPONENTS(MAX_COMPONENTS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(w_cmd_valid),
        .o_cmd_ready(w_cmd_ready),
        .i_cmd      (w_cmd),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_item     (o_item)
    );
endmodule

// ===== rtl/core/kfli_front.sv =====
module kfli_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  kfli_pkg::t_in_item i_item,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output kfli_pkg::t_cmd    o_cmd
);
    import kfli_pkg::*;

    t_cmd       r_q [QUEUE_DEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_push, w_pop;

    // Classify the incoming item and saturate the component count
    always_comb begin
        w_cmd.kind       = t_kind'(i_item.kind);
        w_cmd.time_point = i_item.time_point;
        w_cmd.component_count = (i_item.component_count > 3'd4) ? 3'd4
                                                                 : i_item.component_count;
        w_cmd.values[0] = i_item.in_value0;
        w_cmd.values[1] = i_item.in_value1;
        w_cmd.values[2] = i_item.in_value2;
        w_cmd.values[3] = i_item.in_value3;
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    // Hold items in a two-entry queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_cmd;
    end
endmodule

// ===== rtl/core/kfli_div.sv =====
module kfli_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quot
);
    import kfli_pkg::*;

    logic [63:0] r_q;
    logic [32:0] r_rem;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [32:0] w_sh;
    logic        w_ge;

    // Restoring division, one quotient bit a cycle
    assign w_sh = {r_rem[31:0], r_q[63]};
    assign w_ge = w_sh >= {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= 7'd0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= 33'd0;
        end else if (r_busy) begin
            r_q   <= {r_q[62:0], w_ge};
            r_rem <= w_ge ? (w_sh - {1'b0, i_den}) : w_sh;
        end
    end

    assign o_quot = r_q;
endmodule

// ===== rtl/core/kfli_back.sv =====
module kfli_back #(
    parameter int MAX_KEYS       = kfli_pkg::MAX_KEYS_DEF,
    parameter int MAX_COMPONENTS = kfli_pkg::MAX_COMPONENTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    input  kfli_pkg::t_cmd     i_cmd,
    output logic               o_valid,
    input  logic               i_ready,
    output kfli_pkg::t_out_item o_item
);
    import kfli_pkg::*;

    localparam int KW = $clog2(MAX_KEYS);
    localparam int CW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
    localparam int AW = KW + CW;

    // Keyframe stores
    logic [31:0] r_times  [MAX_KEYS];
    logic [2:0]  r_ccnt   [MAX_KEYS];
    logic [31:0] r_vals   [MAX_KEYS*MAX_COMPONENTS];
    logic [KW:0] r_count;

    t_state r_st, n_st;
    t_cmd   r_cmd;
    logic [KW-1:0] r_lo, r_hi, r_addr;
    logic [31:0]   r_trd, r_t0;
    logic [2:0]    r_crd, r_c0, r_n;
    logic [31:0]   r_vrd;
    logic [AW-1:0] r_vaddr;
    logic [31:0]   r_span, r_dt, r_v0;
    logic [2:0]    r_ci;
    logic          r_neg;
    logic [3:0][31:0] r_res;
    logic [1:0]    r_status;
    logic [63:0]   r_prod;
    logic          r_copy;
    logic [1:0]    r_ph;

    logic          w_div_start, w_div_done;
    logic [63:0]   w_quot;
    logic [KW-1:0] w_mid;
    logic [KW:0]   w_sum;
    logic          w_pop;
    logic signed [32:0] w_diff;
    logic [32:0]   w_mag;

    assign o_cmd_ready = (r_st == S_IDLE) && !o_valid;
    assign w_pop       = i_cmd_valid && o_cmd_ready;
    assign w_sum       = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid       = w_sum[KW:1];
    assign w_diff      = $signed({r_vrd[31], r_vrd}) - $signed({r_v0[31], r_v0});
    assign w_mag       = w_diff[32] ? (33'd0 - w_diff) : w_diff;

    kfli_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_num  (r_prod),
        .i_den  (r_span),
        .o_done (w_div_done),
        .o_quot (w_quot)
    );

    // Next state
    always_comb begin
        n_st        = r_st;
        w_div_start = 1'b0;
        case (r_st)
            S_IDLE:      n_st = w_pop ? S_RD_FIRST : S_IDLE;
            S_RD_FIRST:  begin
                if (r_cmd.kind != KIND_EVAL || r_count == '0) n_st = S_OUT;
                else n_st = S_CHK_FIRST;
            end
            S_CHK_FIRST: begin
                if (r_count == {{KW{1'b0}}, 1'b1} || r_cmd.time_point <= r_trd)
                    n_st = S_COMP_RD;
                else n_st = S_RD_LAST;
            end
            S_RD_LAST:   n_st = S_CHK_LAST;
            S_CHK_LAST:  n_st = (r_cmd.time_point >= r_trd) ? S_COMP_RD : S_SRCH_RD;
            S_SRCH_RD:   n_st = ({1'b0, r_lo} + 1'b1 < {1'b0, r_hi}) ? S_SRCH_WAIT
                                                                       : S_PAIR_RD;
            S_SRCH_WAIT: n_st = S_SRCH_CHK;
            S_SRCH_CHK:  n_st = S_SRCH_RD;
            S_PAIR_RD:   n_st = S_PAIR_WAIT;
            S_PAIR_WAIT: n_st = S_PAIR_SET;
            S_PAIR_SET:  n_st = S_COMP_RD;
            S_COMP_RD:   n_st = (r_ci >= r_n) ? S_OUT : S_DIV;
            S_DIV:       begin
                w_div_start = !r_copy && (r_ph == 2'd2);
                if (r_copy || w_div_done) n_st = S_COMP_WR;
            end
            S_COMP_WR:   n_st = S_COMP_RD;
            S_OUT:       n_st = S_IDLE;
            default:     n_st = S_IDLE;
        endcase
    end

    // Sequence each item: update the key count, search and evaluate, then output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_count <= '0;
            o_valid <= 1'b0;
            r_ci    <= 3'd0;
        end else begin
            r_st <= n_st;
            if (o_valid && i_ready) o_valid <= 1'b0;
            if (r_st == S_IDLE && w_pop) begin
                r_cmd    <= i_cmd;
                r_addr   <= '0;
                r_ci     <= 3'd0;
                if (i_cmd.kind == KIND_CLEAR) r_count <= '0;
                if (i_cmd.kind == KIND_APPEND && r_count == (KW+1)'(MAX_KEYS)) begin
                    r_status <= ST_FULL;
                end else begin
                    r_status <= ST_OK;
                    if (i_cmd.kind == KIND_APPEND) r_count <= r_count + 1'b1;
                end
            end
            case (r_st)
                S_RD_FIRST: begin
                    if (r_cmd.kind == KIND_EVAL && r_count == '0) r_status <= ST_EMPTY;
                    r_lo    <= '0;
                    r_hi    <= KW'(r_count - 1'b1);
                    r_copy  <= 1'b1;
                    r_vaddr <= '0;
                end
                S_CHK_FIRST: begin
                    r_addr <= KW'(r_count - 1'b1);
                    r_n    <= r_crd;
                    r_c0   <= r_crd;
                    r_t0   <= r_trd;
                end
                S_RD_LAST: r_vaddr <= AW'(r_hi) * AW'(MAX_COMPONENTS);
                S_CHK_LAST: r_n <= r_crd;
                S_SRCH_RD: r_addr <= w_mid;
                S_SRCH_CHK: begin
                    if (r_trd <= r_cmd.time_point) begin
                        r_lo <= r_addr;
                        r_t0 <= r_trd;
                        r_c0 <= r_crd;
                    end else begin
                        r_hi <= r_addr;
                    end
                end
                S_PAIR_RD: r_addr <= r_hi;
                S_PAIR_SET: begin
                    r_copy  <= 1'b0;
                    r_n     <= (r_crd < r_c0) ? r_crd : r_c0;
                    r_span  <= (r_trd > r_t0) ? r_trd - r_t0 : 32'd0;
                    r_dt    <= r_cmd.time_point - r_t0;
                    r_vaddr <= AW'(r_lo) * AW'(MAX_COMPONENTS);
                end
                S_COMP_WR: r_ci <= r_ci + 3'd1;
                S_OUT: begin
                    o_valid <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Registered store reads
    always_ff @(posedge i_clk) begin
        r_trd <= r_times[r_addr];
        r_crd <= r_ccnt[r_addr];
    end

    // Append write
    always_ff @(posedge i_clk) begin
        if (r_st == S_IDLE && w_pop && i_cmd.kind == KIND_APPEND
            && r_count != (KW+1)'(MAX_KEYS)) begin
            r_times[KW'(r_count)] <= i_cmd.time_point;
            r_ccnt[KW'(r_count)]  <= (i_cmd.component_count > 3'(MAX_COMPONENTS))
                                     ? 3'(MAX_COMPONENTS) : i_cmd.component_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_IDLE && w_pop && i_cmd.kind == KIND_APPEND
            && r_count != (KW+1)'(MAX_KEYS)) begin
            for (int c = 0; c < MAX_COMPONENTS; c++)
                r_vals[AW'(KW'(r_count)) * AW'(MAX_COMPONENTS) + AW'(c)] <= i_cmd.values[c];
        end
    end

    // Component pass: read v0 and then v1, form the product for the divide, and write the result; a copy takes v0 alone
    always_ff @(posedge i_clk) begin
        if (r_st == S_IDLE && w_pop) r_res <= '0;
        if (r_st == S_COMP_RD) begin
            r_ph <= 2'd0;
            r_vrd <= r_vals[r_vaddr + AW'(r_ci)];
        end else if (r_st == S_DIV) begin
            if (r_ph == 2'd0) begin
                r_v0 <= r_vrd;
                if (!r_copy)
                    r_vrd <= r_vals[r_vaddr + AW'(MAX_COMPONENTS) + AW'(r_ci)];
                r_ph <= 2'd1;
            end else if (r_ph == 2'd1) begin
                r_neg  <= w_diff[32];
                r_prod <= {32'd0, r_dt} * {31'd0, w_mag};
                r_ph   <= 2'd2;
            end else if (r_ph == 2'd2) begin
                r_ph <= 2'd3;
            end
        end
        if (r_st == S_COMP_WR) begin
            if (r_copy) r_res[r_ci[1:0]] <= r_v0;
            else r_res[r_ci[1:0]] <= r_neg ? r_v0 - w_quot[31:0] : r_v0 + w_quot[31:0];
        end
    end

    assign o_item.status       = r_status;
    assign o_item.result_count = (r_status == ST_OK && r_cmd.kind == KIND_EVAL) ? r_n : 3'd0;
    assign o_item.out_value0   = r_res[0];
    assign o_item.out_value1   = r_res[1];
    assign o_item.out_value2   = r_res[2];
    assign o_item.out_value3   = r_res[3];
endmodule
